FILE: rtl/burst_repeat_majority_vote_macros.svh
// Assertion macros shared by the checker of the burst majority voter.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BURST_REPEAT_MAJORITY_VOTE_MACROS_SVH
`define BURST_REPEAT_MAJORITY_VOTE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRMV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brmv assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BRMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brmv assertion failed");

`endif

FILE: rtl/brmv_pkg.sv
`timescale 1ns / 1ps
package brmv_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;
  typedef logic [0:0]        cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_REPEAT_COUNT  = 1'b0;
  localparam cfg_idx_t CFG_VOTE_MAJORITY = 1'b1;

  localparam cfg_data_t REPEAT_COUNT_RST  = 4'd5;
  localparam cfg_data_t VOTE_MAJORITY_RST = 4'd3;

  // Control that the sequencer broadcasts to every cell of the copy ring.
  typedef struct packed {
    logic clear;
    logic rotate;
  } cell_ctl_t;

endpackage

FILE: rtl/brmv_if.sv
`timescale 1ns / 1ps
interface brmv_in_if;
  logic           valid;
  logic           ready;
  logic           rx_good;
  logic           rx_is_idle;
  brmv_pkg::byte_t rx_byte;

  modport source (output valid, output rx_good, output rx_is_idle, output rx_byte,
                  input ready);
  modport sink (input valid, input rx_good, input rx_is_idle, input rx_byte,
                output ready);
endinterface

interface brmv_out_if;
  logic            valid;
  logic            ready;
  logic            finalized;
  logic            success;
  brmv_pkg::byte_t voted_byte;

  modport source (output valid, output finalized, output success, output voted_byte,
                  input ready);
  modport sink (input valid, input finalized, input success, input voted_byte,
                output ready);
endinterface

FILE: rtl/brmv_cell.sv
`timescale 1ns / 1ps
// One slot of the copy ring: holds a stored copy and its valid flag, takes the
// neighbor's copy when the ring rotates and flags a match against the candidate.
module brmv_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  brmv_pkg::cell_ctl_t ctl,
  input  logic                wr_en,
  input  brmv_pkg::byte_t     wr_byte,
  input  brmv_pkg::byte_t     nb_byte,
  input  logic                nb_valid,
  input  brmv_pkg::byte_t     cand_byte,
  output brmv_pkg::byte_t     byte_o,
  output logic                valid_o,
  output logic                match_o
);

  brmv_pkg::byte_t byte_r;
  logic            valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end else if (ctl.rotate) begin
      valid_r <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= wr_byte;
    end else if (ctl.rotate) begin
      byte_r <= nb_byte;
    end
  end

  assign byte_o  = byte_r;
  assign valid_o = valid_r;
  assign match_o = valid_r && (byte_r == cand_byte);

endmodule

FILE: rtl/burst_repeat_majority_vote.sv
`timescale 1ns / 1ps
// Majority voter over a burst of repeated receive slots.
// The in_ch channel carries one transaction per receive slot (rx_good,
// rx_is_idle, rx_byte); the out_ch channel returns exactly one transaction
// per input transaction (finalized, success, voted_byte). Both use a
// valid/ready handshake. The cfg_ port writes repeat_count (index 0) and
// vote_majority (index 1); write it only while the block is idle. A slot
// that does not close a burst yields its result in the cycle after
// acceptance. A slot that closes a burst starts a vote in a ring of
// MAX_REPEATS cells: each cycle the ring compares every held copy with the
// copy in cell 0 and rotates by one, until that copy has the majority
// (success) or the last held copy was tried (failure). One slot is
// processed at a time; the next slot is taken once the previous one has
// its result in the output register. A stalled receiver holds the output
// register, and no new slot is taken until it frees. The synchronous reset
// clears the burst, the ring valid flags and the output register and
// restores repeat_count 5, majority 3.
module burst_repeat_majority_vote #(
  parameter int MAX_REPEATS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  brmv_in_if.sink                in_ch,
  brmv_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  brmv_pkg::cfg_idx_t     cfg_idx,
  input  brmv_pkg::cfg_data_t    cfg_wdata
);

  // Counters hold values up to MAX_REPEATS; compares are done at 5 bits,
  // enough for any depth up to 31.
  localparam int CNT_W = $clog2(MAX_REPEATS + 1);
  localparam logic [4:0] MAX_REPS = 5'(MAX_REPEATS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_VOTE = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Configuration registers.
  brmv_pkg::cfg_data_t rep_cnt_r;
  brmv_pkg::cfg_data_t vote_maj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_cnt_r  <= brmv_pkg::REPEAT_COUNT_RST;
      vote_maj_r <= brmv_pkg::VOTE_MAJORITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        brmv_pkg::CFG_REPEAT_COUNT:  rep_cnt_r  <= cfg_wdata;
        brmv_pkg::CFG_VOTE_MAJORITY: vote_maj_r <= cfg_wdata;
        default:                     rep_cnt_r  <= rep_cnt_r;
      endcase
    end
  end

  // Effective repeat count: zero acts as one, and it saturates at the ring depth.
  logic [4:0] reps;
  always_comb begin
    reps = {1'b0, rep_cnt_r};
    if (reps == 5'd0) begin
      reps = 5'd1;
    end
    if (reps > MAX_REPS) begin
      reps = MAX_REPS;
    end
  end

  // Sequencer and burst state.
  logic [1:0]       state_r;
  logic             active_r;
  logic [CNT_W-1:0] slots_r;
  logic [CNT_W-1:0] copies_r;
  logic [CNT_W-1:0] vote_idx_r;
  logic             res_success_r;
  brmv_pkg::byte_t  res_byte_r;

  // Output register.
  logic             out_valid_r;
  logic             out_fin_r;
  logic             out_succ_r;
  brmv_pkg::byte_t  out_byte_r;

  logic out_free;
  logic in_accept;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_accept = in_ch.valid && in_ch.ready;

  // Effect of the slot on offer: which copy is stored, and whether it closes the burst.
  logic             good_data;
  logic             good_idle;
  logic             active_nxt;
  logic [CNT_W-1:0] slots_nxt;
  logic [CNT_W-1:0] copies_nxt;
  logic             store_en;
  logic [CNT_W-1:0] store_idx;
  logic             close_burst;
  logic [4:0]       slots_inc;

  assign good_data = in_ch.rx_good && !in_ch.rx_is_idle;
  assign good_idle = in_ch.rx_good && in_ch.rx_is_idle;

  always_comb begin
    active_nxt  = active_r;
    slots_nxt   = slots_r;
    copies_nxt  = copies_r;
    store_en    = 1'b0;
    store_idx   = copies_r;
    close_burst = 1'b0;
    slots_inc   = 5'(slots_r);
    if (!active_r) begin
      // Only a good data slot opens a burst; anything else is ignored.
      if (good_data) begin
        active_nxt  = 1'b1;
        slots_nxt   = CNT_W'(1);
        copies_nxt  = CNT_W'(1);
        store_en    = 1'b1;
        store_idx   = '0;
        close_burst = (reps <= 5'd1);
      end
    end else if (good_idle) begin
      // A good idle frame ends the burst early.
      close_burst = 1'b1;
    end else begin
      if (good_data && (5'(copies_r) < reps)) begin
        store_en   = 1'b1;
        copies_nxt = copies_r + CNT_W'(1);
      end
      if (5'(slots_r) < reps) begin
        slots_inc = 5'(slots_r) + 5'd1;
      end
      slots_nxt   = CNT_W'(slots_inc);
      close_burst = (slots_inc >= reps);
    end
  end

  // Copy ring.
  logic [MAX_REPEATS-1:0] cell_valid;
  logic [MAX_REPEATS-1:0] cell_match;
  brmv_pkg::byte_t        cell_byte [MAX_REPEATS];
  brmv_pkg::cell_ctl_t    cell_ctl;
  brmv_pkg::byte_t        cand_byte;

  assign cand_byte = cell_byte[0];

  for (genvar j = 0; j < MAX_REPEATS; j++) begin : g_cell
    brmv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .wr_en     (in_accept && store_en && (store_idx == CNT_W'(j))),
      .wr_byte   (in_ch.rx_byte),
      .nb_byte   (cell_byte[(j + 1) % MAX_REPEATS]),
      .nb_valid  (cell_valid[(j + 1) % MAX_REPEATS]),
      .cand_byte (cand_byte),
      .byte_o    (cell_byte[j]),
      .valid_o   (cell_valid[j]),
      .match_o   (cell_match[j])
    );
  end

  // Number of held copies equal to the candidate in cell 0.
  logic [CNT_W-1:0] match_cnt;
  always_comb begin
    match_cnt = '0;
    for (int k = 0; k < MAX_REPEATS; k++) begin
      match_cnt = match_cnt + CNT_W'(cell_match[k]);
    end
  end

  logic vote_hit;
  logic vote_last;
  logic emit_go;
  assign vote_hit  = cell_valid[0] && (5'(match_cnt) >= {1'b0, vote_maj_r});
  assign vote_last = (5'(vote_idx_r) + 5'd1) >= 5'(copies_r);
  assign emit_go   = (state_r == ST_EMIT) && out_free;

  assign cell_ctl.clear  = emit_go;
  assign cell_ctl.rotate = (state_r == ST_VOTE) && !vote_hit && !vote_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      active_r   <= 1'b0;
      slots_r    <= '0;
      copies_r   <= '0;
      vote_idx_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            copies_r <= copies_nxt;
            if (close_burst) begin
              // The burst closes; the copies stay in the ring for the vote.
              active_r   <= 1'b0;
              slots_r    <= '0;
              vote_idx_r <= '0;
              state_r    <= ST_VOTE;
            end else begin
              active_r <= active_nxt;
              slots_r  <= slots_nxt;
            end
          end
        end
        ST_VOTE: begin
          if (vote_hit || vote_last) begin
            state_r <= ST_EMIT;
          end else begin
            vote_idx_r <= vote_idx_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            copies_r <= '0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_VOTE) && (vote_hit || vote_last)) begin
      res_success_r <= vote_hit;
      res_byte_r    <= vote_hit ? cand_byte : '0;
    end
  end

  // Output register: loaded by a slot that leaves the burst open, or by the vote.
  logic load_open;
  assign load_open = in_accept && !close_burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_open || emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_open) begin
      out_fin_r  <= 1'b0;
      out_succ_r <= 1'b0;
      out_byte_r <= '0;
    end else if (emit_go) begin
      out_fin_r  <= 1'b1;
      out_succ_r <= res_success_r;
      out_byte_r <= res_byte_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.finalized  = out_fin_r;
  assign out_ch.success    = out_succ_r;
  assign out_ch.voted_byte = out_byte_r;

endmodule

FILE: rtl/brmv_checker.sv
`timescale 1ns / 1ps
`include "burst_repeat_majority_vote_macros.svh"
// Port-level checks of the burst majority voter.
module brmv_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_finalized,
  input logic            out_success,
  input brmv_pkg::byte_t out_voted_byte
);

  // A new slot is never taken while a result is stuck in the output register.
  `BRMV_ASSERT_SAME(a_no_accept_on_stall, in_valid && in_ready, !out_valid || out_ready)
  // A success is only reported on a transaction that closes a burst.
  `BRMV_ASSERT_SAME(a_success_final, out_valid && out_success, out_finalized)
  // Without a success the voted byte is zero.
  `BRMV_ASSERT_SAME(a_byte_zero, out_valid && !out_success, out_voted_byte == '0)
  // A stalled result stays offered.
  `BRMV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // A stalled result keeps its payload.
  `BRMV_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_finalized) && $stable(out_success) && $stable(out_voted_byte))

endmodule

bind burst_repeat_majority_vote brmv_checker u_brmv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_finalized  (out_ch.finalized),
  .out_success    (out_ch.success),
  .out_voted_byte (out_ch.voted_byte)
);
